FILE: sv/osle_pkg.sv
// package: constants and codes shared by the order sequence list engine
`default_nettype none
package osle_pkg;
	localparam int MaxOrders = 64;
	localparam int AddrW = $clog2(MaxOrders);
	localparam int IdW = 7;
	localparam int CntW = $clog2(MaxOrders + 1);

	typedef enum logic [3:0] {
		FN_APPEND = 4'd0,
		FN_INSERT = 4'd1,
		FN_DELETE = 4'd2,
		FN_REMOVE = 4'd3,
		FN_SWAP = 4'd4,
		FN_REVERSE = 4'd5,
		FN_EXCHANGE = 4'd6,
		FN_QUERY = 4'd7,
		FN_READ = 4'd8
	} func_t;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NOOP = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;
endpackage
`default_nettype wire

FILE: sv/osle_mem.sv
// list storage memory, one write port and one registered read port
`default_nettype none
module osle_mem (
	input wire logic clk,
	input wire logic we,
	input wire logic [osle_pkg::AddrW-1:0] waddr,
	input wire logic [osle_pkg::IdW-1:0] wdata,
	input wire logic [osle_pkg::AddrW-1:0] raddr,
	output logic [osle_pkg::IdW-1:0] rdata
);
	logic [osle_pkg::IdW-1:0] mem_q [osle_pkg::MaxOrders];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: sv/order_sequence_list_engine.sv
// top level: sequencer around the list memory and the shared position counter
`default_nettype none
// One operation is taken when start is high and busy is low; its result shows for one
// cycle under done. Nothing stalls the result side. Each operation walks the list
// memory through its single read port and single write port: a lookup scans one
// entry a cycle, up to list_length entries, insert and erase shift the tail one entry
// at a time (a read state, then a write state), and reverse swaps one pair at a time
// (read low, read high, write low, write high). An unused code goes straight to the
// finish state; the longest operation is an insert at the head of a list one short
// of full (full scan, then full shift). The accepted flags are cleared at reset at once.
module order_sequence_list_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [3:0] func,
	input wire logic [6:0] order_a,
	input wire logic [6:0] order_b,
	input wire logic [6:0] pos_a,
	input wire logic [6:0] pos_b,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [6:0] cfg_data,
	output logic done,
	output logic [1:0] status,
	output logic [6:0] read_order,
	output logic flag_out,
	output logic [6:0] list_length
);
	localparam int AW = osle_pkg::AddrW;
	localparam int CW = osle_pkg::CntW;
	localparam int IW = osle_pkg::IdW;

	typedef enum logic [3:0] {
		S_IDLE, S_FIND_A, S_FIND_B, S_DECIDE, S_SHR_RD, S_SHR_WR, S_SHL_RD, S_SHL_WR,
		S_REV_RDL, S_REV_RDH, S_REV_WRL, S_REV_WRH, S_READ, S_WRITE1, S_WRITE2, S_FINISH
	} state_t;

	state_t state_q;
	logic [3:0] func_q;
	logic [IW-1:0] oa_q, ob_q, pa_q, pb_q, cfg_q, tmp_q, rd_q;
	logic [CW-1:0] cnt_q, idx_q, hi_q, ia_q, ib_q;
	logic fa_q, fb_q;
	logic [1:0] st_q;
	logic fl_q;
	logic [osle_pkg::MaxOrders-1:0] flags_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [IW-1:0] wdata, rdata;

	logic [IW-1:0] lim_n;
	logic va, vb;
	assign lim_n = (cfg_q > IW'(osle_pkg::MaxOrders)) ? IW'(osle_pkg::MaxOrders) : cfg_q;
	assign va = (oa_q != '0) && (oa_q <= lim_n);
	assign vb = (ob_q != '0) && (ob_q <= lim_n);

	osle_mem u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// scan read address is driven from the counter; data arrives from the registered read port in the next cycle
	logic [CW-1:0] scan_idx;
	logic scan_hit;
	assign scan_idx = idx_q - CW'(1);

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = idx_q[AW-1:0];
		scan_hit = 1'b0;
		unique case (state_q) inside
			S_FIND_A, S_FIND_B: begin
				scan_hit = (idx_q != '0) && (rdata == ((state_q == S_FIND_A) ? oa_q : ob_q));
			end
			S_SHR_RD: raddr = AW'(idx_q - CW'(1));
			S_SHR_WR: begin
				we = 1'b1; waddr = idx_q[AW-1:0]; wdata = rdata;
			end
			S_SHL_RD: raddr = AW'(idx_q + CW'(1));
			S_SHL_WR: begin
				we = 1'b1; waddr = idx_q[AW-1:0]; wdata = rdata;
			end
			S_REV_RDL: raddr = idx_q[AW-1:0];
			S_REV_RDH: raddr = AW'(hi_q - CW'(1));
			S_REV_WRL: begin
				we = 1'b1; waddr = idx_q[AW-1:0]; wdata = rdata;
			end
			S_REV_WRH: begin
				we = 1'b1; waddr = AW'(hi_q - CW'(1)); wdata = tmp_q;
			end
			S_READ: raddr = pa_q[AW-1:0];
			S_WRITE1: begin
				we = 1'b1; waddr = idx_q[AW-1:0]; wdata = tmp_q;
			end
			S_WRITE2: begin
				if (func_q == osle_pkg::FN_SWAP) begin
					we = 1'b1; waddr = ib_q[AW-1:0]; wdata = oa_q;
				end else if (func_q != osle_pkg::FN_READ) begin
					we = 1'b1; waddr = idx_q[AW-1:0]; wdata = tmp_q;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cfg_q <= 7'd64;
			cnt_q <= '0;
			flags_q <= '0;
			func_q <= '0;
			oa_q <= '0;
			ob_q <= '0;
			pa_q <= '0;
			pb_q <= '0;
			tmp_q <= '0;
			rd_q <= '0;
			idx_q <= '0;
			hi_q <= '0;
			ia_q <= '0;
			ib_q <= '0;
			fa_q <= 1'b0;
			fb_q <= 1'b0;
			st_q <= '0;
			fl_q <= 1'b0;
			done <= 1'b0;
			status <= '0;
			read_order <= '0;
			flag_out <= 1'b0;
			list_length <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			unique case (state_q) inside
				S_IDLE: begin
					if (start) begin
						func_q <= func;
						oa_q <= order_a;
						ob_q <= order_b;
						pa_q <= pos_a;
						pb_q <= pos_b;
						idx_q <= '0;
						fa_q <= 1'b0;
						fb_q <= 1'b0;
						st_q <= osle_pkg::ST_NOOP;
						rd_q <= '0;
						fl_q <= 1'b0;
						unique case (func) inside
							osle_pkg::FN_READ: state_q <= S_READ;
							osle_pkg::FN_REVERSE: state_q <= S_DECIDE;
							osle_pkg::FN_APPEND, osle_pkg::FN_INSERT, osle_pkg::FN_DELETE,
							osle_pkg::FN_REMOVE, osle_pkg::FN_SWAP, osle_pkg::FN_EXCHANGE,
							osle_pkg::FN_QUERY: state_q <= S_FIND_A;
							default: state_q <= S_FINISH;
						endcase
					end
				end
				S_FIND_A, S_FIND_B: begin
					if (scan_hit) begin
						if (state_q == S_FIND_A) begin
							fa_q <= 1'b1; ia_q <= scan_idx;
						end else begin
							fb_q <= 1'b1; ib_q <= scan_idx;
						end
					end
					if (scan_hit || idx_q >= cnt_q) begin
						idx_q <= '0;
						state_q <= (state_q == S_FIND_A &&
							(func_q == osle_pkg::FN_SWAP || func_q == osle_pkg::FN_EXCHANGE))
							? S_FIND_B : S_DECIDE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_DECIDE: begin
					state_q <= S_FINISH;
					case (func_q) inside
						osle_pkg::FN_APPEND, osle_pkg::FN_INSERT: begin
							if (!va) st_q <= osle_pkg::ST_RANGE;
							else if (fa_q) st_q <= osle_pkg::ST_NOOP;
							else if (cnt_q >= CW'(osle_pkg::MaxOrders) ||
								(func_q == osle_pkg::FN_INSERT && CW'(pa_q) > cnt_q))
								st_q <= osle_pkg::ST_RANGE;
							else begin
								st_q <= osle_pkg::ST_DONE;
								flags_q[AW'(oa_q - 7'd1)] <= 1'b1;
								hi_q <= (func_q == osle_pkg::FN_APPEND) ? cnt_q : CW'(pa_q);
								idx_q <= cnt_q;
								tmp_q <= oa_q;
								state_q <= S_SHR_RD;
							end
						end
						osle_pkg::FN_DELETE, osle_pkg::FN_REMOVE, osle_pkg::FN_QUERY: begin
							if (!va) st_q <= osle_pkg::ST_RANGE;
							else if (!fa_q) st_q <= osle_pkg::ST_MISSING;
							else begin
								st_q <= osle_pkg::ST_DONE;
								if (func_q == osle_pkg::FN_QUERY) begin
									fl_q <= flags_q[AW'(oa_q - 7'd1)];
								end else begin
									if (func_q == osle_pkg::FN_DELETE)
										flags_q[AW'(oa_q - 7'd1)] <= 1'b0;
									idx_q <= ia_q;
									state_q <= S_SHL_RD;
								end
							end
						end
						osle_pkg::FN_SWAP: begin
							if (!va || !vb) st_q <= osle_pkg::ST_RANGE;
							else if (!fa_q || !fb_q) st_q <= osle_pkg::ST_MISSING;
							else begin
								st_q <= osle_pkg::ST_DONE;
								idx_q <= ia_q;
								tmp_q <= ob_q;
								state_q <= S_WRITE1;
							end
						end
						osle_pkg::FN_EXCHANGE: begin
							if (!va || !vb) st_q <= osle_pkg::ST_RANGE;
							else if (!fa_q) st_q <= osle_pkg::ST_MISSING;
							else if (fb_q) st_q <= osle_pkg::ST_NOOP;
							else begin
								st_q <= osle_pkg::ST_DONE;
								flags_q[AW'(oa_q - 7'd1)] <= 1'b0;
								flags_q[AW'(ob_q - 7'd1)] <= 1'b1;
								idx_q <= ia_q;
								tmp_q <= ob_q;
								state_q <= S_WRITE2;
							end
						end
						osle_pkg::FN_REVERSE: begin
							if (pa_q > pb_q || CW'(pb_q) > cnt_q) st_q <= osle_pkg::ST_RANGE;
							else begin
								st_q <= osle_pkg::ST_DONE;
								idx_q <= CW'(pa_q);
								hi_q <= CW'(pb_q);
								state_q <= S_REV_RDL;
							end
						end
						default: st_q <= osle_pkg::ST_NOOP;
					endcase
				end
				S_SHR_RD: begin
					if (idx_q > hi_q) state_q <= S_SHR_WR;
					else begin
						state_q <= S_WRITE2;
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_SHR_WR: begin
					idx_q <= idx_q - CW'(1);
					state_q <= S_SHR_RD;
				end
				S_SHL_RD: begin
					if (idx_q + CW'(1) < cnt_q) state_q <= S_SHL_WR;
					else begin
						cnt_q <= cnt_q - CW'(1);
						state_q <= S_FINISH;
					end
				end
				S_SHL_WR: begin
					idx_q <= idx_q + CW'(1);
					state_q <= S_SHL_RD;
				end
				S_REV_RDL: begin
					if (idx_q + CW'(1) < hi_q) state_q <= S_REV_RDH;
					else state_q <= S_FINISH;
				end
				S_REV_RDH: begin
					tmp_q <= rdata;
					state_q <= S_REV_WRL;
				end
				S_REV_WRL: state_q <= S_REV_WRH;
				S_REV_WRH: begin
					idx_q <= idx_q + CW'(1);
					hi_q <= hi_q - CW'(1);
					state_q <= S_REV_RDL;
				end
				S_READ: begin
					state_q <= S_FINISH;
					if (CW'(pa_q) >= cnt_q) st_q <= osle_pkg::ST_RANGE;
					else begin
						st_q <= osle_pkg::ST_DONE;
						state_q <= S_WRITE2;
						func_q <= osle_pkg::FN_READ;
					end
				end
				S_WRITE1: state_q <= S_WRITE2;
				S_WRITE2: begin
					if (func_q == osle_pkg::FN_READ) rd_q <= rdata;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					done <= 1'b1;
					status <= st_q;
					read_order <= rd_q;
					flag_out <= fl_q;
					list_length <= IW'(cnt_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cfg_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !busy);
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy);
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done);
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(osle_pkg::MaxOrders));
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		done && (read_order != '0) |-> status == osle_pkg::ST_DONE);
endmodule
`default_nettype wire

FILE: verif/tb_order_sequence_list_engine.sv
// testbench: order sequence list engine checked against an in-bench list predictor
`timescale 1ns / 100ps
module tb_order_sequence_list_engine;
	localparam logic [3:0] FN_UNUSED_LO = 4'd9;
	localparam logic [3:0] FN_UNUSED_HI = 4'd15;
	localparam int WatchLimit = 4000;
	localparam int RandItems = 1080;

	typedef struct packed {
		logic [1:0] st;
		logic [6:0] rd;
		logic fl;
		logic [6:0] len;
	} op_result_t;

	typedef struct {
		logic [3:0] fn;
		logic [6:0] oa;
		logic [6:0] ob;
		logic [6:0] pa;
		logic [6:0] pb;
		bit typed;
		op_result_t res;
	} op_row_t;

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, done, flag_out;
	logic [3:0] func;
	logic [6:0] order_a, order_b, pos_a, pos_b, cfg_data, read_order, list_length;
	logic [1:0] status;

	logic [6:0] list_ids [osle_pkg::MaxOrders];
	bit accepted [osle_pkg::MaxOrders];
	int listed;
	int id_limit;
	op_result_t pending_results[$];
	int errors;
	int quiet_cycles;
	int send_idle_pct;

	order_sequence_list_engine uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .order_a(order_a), .order_b(order_b), .pos_a(pos_a), .pos_b(pos_b),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .status(status), .read_order(read_order), .flag_out(flag_out),
		.list_length(list_length)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic bit id_ok(logic [6:0] id);
		return id >= 1 && int'(id) <= id_limit;
	endfunction

	function automatic int find_pos(logic [6:0] id);
		for (int k = 0; k < listed; k++)
			if (list_ids[k] == id) return k;
		return -1;
	endfunction

	function automatic op_result_t apply_op(logic [3:0] f, logic [6:0] oa, logic [6:0] ob,
			logic [6:0] pa, logic [6:0] pb);
		op_result_t r;
		int ia, ib, lo, hi, p;
		logic [6:0] t;
		r = '0;
		r.st = osle_pkg::ST_NOOP;
		case (f) inside
			osle_pkg::FN_APPEND, osle_pkg::FN_INSERT: begin
				p = (f == osle_pkg::FN_APPEND) ? listed : int'(pa);
				if (!id_ok(oa)) r.st = osle_pkg::ST_RANGE;
				else if (find_pos(oa) >= 0) r.st = osle_pkg::ST_NOOP;
				else if (listed >= osle_pkg::MaxOrders || p > listed) r.st = osle_pkg::ST_RANGE;
				else begin
					for (int k = listed; k > p; k--) list_ids[k] = list_ids[k - 1];
					list_ids[p] = oa;
					listed++;
					accepted[oa - 1] = 1;
					r.st = osle_pkg::ST_DONE;
				end
			end
			osle_pkg::FN_DELETE, osle_pkg::FN_REMOVE, osle_pkg::FN_QUERY: begin
				ia = find_pos(oa);
				if (!id_ok(oa)) r.st = osle_pkg::ST_RANGE;
				else if (ia < 0) r.st = osle_pkg::ST_MISSING;
				else begin
					if (f == osle_pkg::FN_QUERY) r.fl = accepted[oa - 1];
					else begin
						for (int k = ia; k + 1 < listed; k++) list_ids[k] = list_ids[k + 1];
						listed--;
						if (f == osle_pkg::FN_DELETE) accepted[oa - 1] = 0;
					end
					r.st = osle_pkg::ST_DONE;
				end
			end
			osle_pkg::FN_SWAP: begin
				ia = find_pos(oa);
				ib = find_pos(ob);
				if (!id_ok(oa) || !id_ok(ob)) r.st = osle_pkg::ST_RANGE;
				else if (ia < 0 || ib < 0) r.st = osle_pkg::ST_MISSING;
				else begin
					list_ids[ia] = ob;
					list_ids[ib] = oa;
					r.st = osle_pkg::ST_DONE;
				end
			end
			osle_pkg::FN_REVERSE: begin
				if (pa > pb || int'(pb) > listed) r.st = osle_pkg::ST_RANGE;
				else begin
					lo = pa;
					hi = pb;
					while (lo + 1 < hi) begin
						t = list_ids[lo];
						list_ids[lo] = list_ids[hi - 1];
						list_ids[hi - 1] = t;
						lo++;
						hi--;
					end
					r.st = osle_pkg::ST_DONE;
				end
			end
			osle_pkg::FN_EXCHANGE: begin
				ia = find_pos(oa);
				if (!id_ok(oa) || !id_ok(ob)) r.st = osle_pkg::ST_RANGE;
				else if (ia < 0) r.st = osle_pkg::ST_MISSING;
				else if (find_pos(ob) >= 0) r.st = osle_pkg::ST_NOOP;
				else begin
					list_ids[ia] = ob;
					accepted[ob - 1] = 1;
					accepted[oa - 1] = 0;
					r.st = osle_pkg::ST_DONE;
				end
			end
			osle_pkg::FN_READ: begin
				if (int'(pa) >= listed) r.st = osle_pkg::ST_RANGE;
				else begin
					r.rd = list_ids[pa];
					r.st = osle_pkg::ST_DONE;
				end
			end
			default: r.st = osle_pkg::ST_NOOP;
		endcase
		r.len = listed[6:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		op_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) report_mismatch("unexpected result", 1, 0);
			else begin
				want = pending_results.pop_front();
				if (status != want.st) report_mismatch("status", status, want.st);
				if (read_order != want.rd) report_mismatch("read_order", read_order, want.rd);
				if (flag_out != want.fl) report_mismatch("flag_out", flag_out, want.fl);
				if (list_length != want.len)
					report_mismatch("list_length", list_length, want.len);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// start stays high after a transfer; the next call either idles or drives again
	task automatic issue_op(op_row_t row);
		op_result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			start <= 0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		start <= 1;
		func <= row.fn;
		order_a <= row.oa;
		order_b <= row.ob;
		pos_a <= row.pa;
		pos_b <= row.pb;
		do @(posedge clk); while (busy);
		r = apply_op(row.fn, row.oa, row.ob, row.pa, row.pb);
		if (row.typed) r = row.res;
		pending_results = {pending_results, r};
	endtask

	task automatic write_order_count(logic [6:0] value);
		start <= 0;
		@(posedge clk);
		wait (pending_results.size() == 0);
		repeat (8) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		id_limit = (value > osle_pkg::MaxOrders) ? osle_pkg::MaxOrders : value;
		cfg_valid <= 0;
	endtask

	function automatic logic [6:0] pick_id();
		if ($urandom_range(15) == 0) return 7'($urandom());
		return 7'($urandom_range(id_limit + 1, 0));
	endfunction

	function automatic logic [6:0] pick_pos();
		if ($urandom_range(15) == 0) return 7'($urandom());
		return 7'($urandom_range(listed + 1, 0));
	endfunction

	function automatic op_row_t random_op();
		op_row_t row;
		int w;
		row.typed = 0;
		row.res = '0;
		w = $urandom_range(99);
		if (w < 30)
			row.fn = ($urandom_range(1) == 0) ? osle_pkg::FN_APPEND : osle_pkg::FN_INSERT;
		else if (w < 44)
			row.fn = ($urandom_range(1) == 0) ? osle_pkg::FN_DELETE : osle_pkg::FN_REMOVE;
		else if (w < 96)
			row.fn = 4'($urandom_range(osle_pkg::FN_READ, osle_pkg::FN_SWAP));
		else row.fn = 4'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
		row.oa = pick_id();
		row.ob = pick_id();
		row.pa = pick_pos();
		row.pb = pick_pos();
		// mostly pick listed orders so lookups succeed
		if (listed > 0 && $urandom_range(99) < 60) row.oa = list_ids[$urandom_range(listed - 1)];
		if (listed > 0 && row.fn == osle_pkg::FN_SWAP && $urandom_range(99) < 70)
			row.ob = list_ids[$urandom_range(listed - 1)];
		if (row.fn == osle_pkg::FN_REVERSE && row.pa > row.pb && $urandom_range(3) != 0) begin
			row.pa = row.pb;
			row.pb = pick_pos();
		end
		return row;
	endfunction

	op_row_t directed [] = '{
		'{osle_pkg::FN_READ, 0, 0, 0, 0, 1, '{osle_pkg::ST_RANGE, 0, 0, 0}},
		'{osle_pkg::FN_QUERY, 0, 0, 0, 0, 1, '{osle_pkg::ST_RANGE, 0, 0, 0}},
		'{osle_pkg::FN_APPEND, 65, 0, 0, 0, 1, '{osle_pkg::ST_RANGE, 0, 0, 0}},
		'{osle_pkg::FN_DELETE, 5, 0, 0, 0, 1, '{osle_pkg::ST_MISSING, 0, 0, 0}},
		'{osle_pkg::FN_APPEND, 64, 0, 0, 0, 1, '{osle_pkg::ST_DONE, 0, 0, 1}},
		'{osle_pkg::FN_APPEND, 1, 0, 0, 0, 1, '{osle_pkg::ST_DONE, 0, 0, 2}},
		'{osle_pkg::FN_APPEND, 1, 0, 0, 0, 1, '{osle_pkg::ST_NOOP, 0, 0, 2}},
		'{osle_pkg::FN_INSERT, 10, 0, 5, 0, 1, '{osle_pkg::ST_RANGE, 0, 0, 2}},
		'{osle_pkg::FN_INSERT, 10, 0, 0, 0, 1, '{osle_pkg::ST_DONE, 0, 0, 3}},
		'{osle_pkg::FN_READ, 0, 0, 0, 0, 1, '{osle_pkg::ST_DONE, 10, 0, 3}},
		'{osle_pkg::FN_SWAP, 64, 1, 0, 0, 0, '0},
		'{osle_pkg::FN_SWAP, 10, 10, 0, 0, 0, '0},
		'{osle_pkg::FN_REVERSE, 0, 0, 0, 3, 0, '0},
		'{osle_pkg::FN_REVERSE, 0, 0, 2, 1, 1, '{osle_pkg::ST_RANGE, 0, 0, 3}},
		'{osle_pkg::FN_REVERSE, 0, 0, 0, 4, 1, '{osle_pkg::ST_RANGE, 0, 0, 3}},
		'{osle_pkg::FN_EXCHANGE, 10, 20, 0, 0, 0, '0},
		'{osle_pkg::FN_EXCHANGE, 20, 20, 0, 0, 1, '{osle_pkg::ST_NOOP, 0, 0, 3}},
		'{osle_pkg::FN_EXCHANGE, 5, 6, 0, 0, 1, '{osle_pkg::ST_MISSING, 0, 0, 3}},
		'{osle_pkg::FN_QUERY, 10, 0, 0, 0, 1, '{osle_pkg::ST_MISSING, 0, 0, 3}},
		'{osle_pkg::FN_QUERY, 20, 0, 0, 0, 1, '{osle_pkg::ST_DONE, 0, 1, 3}},
		'{osle_pkg::FN_REMOVE, 20, 0, 0, 0, 0, '0},
		'{osle_pkg::FN_QUERY, 20, 0, 0, 0, 0, '0},
		'{FN_UNUSED_HI, 127, 127, 127, 127, 1, '{osle_pkg::ST_NOOP, 0, 0, 2}},
		'{FN_UNUSED_LO, 0, 0, 0, 0, 0, '0},
		'{osle_pkg::FN_DELETE, 64, 0, 0, 0, 0, '0}
	};

	logic [6:0] count_settings [] = '{7'd1, 7'd127, 7'd0, 7'd20, 7'd64, 7'd33};

	initial begin
		arst_n = 0;
		start = 0;
		func = 0;
		order_a = 0;
		order_b = 0;
		pos_a = 0;
		pos_b = 0;
		cfg_valid = 0;
		cfg_data = 0;
		errors = 0;
		quiet_cycles = 0;
		listed = 0;
		id_limit = osle_pkg::MaxOrders;
		send_idle_pct = 26;
		foreach (accepted[i]) accepted[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i]) issue_op(directed[i]);
		write_order_count(7'd64);
		for (int i = 0; i < RandItems; i++) begin
			if (i == RandItems / 3) send_idle_pct = 62;
			if (i == 2 * RandItems / 3) send_idle_pct = 0;
			if (i % 150 == 149) write_order_count(count_settings[(i / 150) % 6]);
			if (i == 500) begin
				start <= 0;
				@(posedge clk);
				wait (pending_results.size() == 0);
			end
			issue_op(random_op());
		end
		start <= 0;
		@(posedge clk);
		wait (pending_results.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule

FILE: files.f
sv/osle_pkg.sv
sv/osle_mem.sv
sv/order_sequence_list_engine.sv
verif/tb_order_sequence_list_engine.sv
